FILE: src/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types, constants and the CRC step function of the hex record parser with CRC-8.
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam int CHAR_W        = 8;
    localparam int LINE_CHARS    = 64;
    localparam int POS_W         = 6;
    localparam int RECORD_BYTES  = 16;
    localparam int RB_IDX_W      = 4;
    localparam int PAYLOAD_MAX   = 13;
    localparam int DEVICES       = 4;
    localparam int SLOT_W        = 2;
    localparam int RINDEX_W      = 11;
    localparam int PLEN_W        = 4;
    localparam int ID_W          = 32;
    localparam int COUNT_MIN     = 3;

    localparam logic [7:0] DEVICE_MARK = 8'had;
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_FOUR   = 8'h34;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_A      = 8'h41;
    // 'A' - 10: a letter digit counts from ten
    localparam logic [7:0] ALPHA_BASE  = 8'h37;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DEVICE = 2'd0,
        KIND_RECORD = 2'd1,
        KIND_ERROR  = 2'd2
    } rec_kind_t;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_ADDRESS   = 3'd1,
        ERR_CRC       = 3'd2,
        ERR_COUNT     = 3'd3,
        ERR_DEVICES   = 3'd4
    } err_code_t;

    // Line classification, decided on the second character
    typedef enum logic [3:0] {
        LK_NONE    = 4'b0001,
        LK_DEVICE  = 4'b0010,
        LK_RECORD  = 4'b0100,
        LK_IGNORE  = 4'b1000
    } line_kind_t;

    // One result run handed from the parser to the result generator
    typedef struct packed {
        rec_kind_t                          kind;
        err_code_t                          err;
        logic [SLOT_W-1:0]                  slot;
        logic [7:0]                         address;
        logic [ID_W-1:0]                    id;
        logic [RINDEX_W-1:0]                rindex;
        logic [7:0]                         command;
        logic [PLEN_W-1:0]                  plen;
        logic [PAYLOAD_MAX-1:0][7:0]        payload;
    } run_load_t;

    // CRC-8, one byte, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: src/hrp_line_parser.sv
// ----------------------------------------------------------------------------
// hrp_line_parser
// Input register, per-character decode, line state, CRC and device tracking.
// Hands one result run to the generator at the end of a line that yields one.
// ----------------------------------------------------------------------------
module hrp_line_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [hrp_pkg::CHAR_W-1:0] in_char,
    input  logic                       in_end,
    input  logic                       gen_idle,
    output logic                       load_valid,
    output hrp_pkg::run_load_t         load
);

    // Input register
    logic                       in_valid_reg;
    logic [hrp_pkg::CHAR_W-1:0] char_reg;
    logic                       end_reg;

    // Line state
    logic [hrp_pkg::POS_W-1:0]  pos_reg, pos_next;
    hrp_pkg::line_kind_t        kind_reg, kind_next;
    logic [7:0]                 first_reg, first_next;
    logic [3:0]                 high_reg, high_next;
    logic [7:0]                 count_reg, count_next;
    logic [7:0]                 laddr_reg, laddr_next;
    logic [7:0]                 mark_reg, mark_next;
    logic [hrp_pkg::ID_W-1:0]   pend_reg, pend_next;
    logic [7:0]                 crc_reg, crc_next;
    logic [7:0]                 scrc_reg, scrc_next;
    logic [7:0]                 rb_reg [hrp_pkg::RECORD_BYTES];

    // Device state
    logic [7:0]                   cur_addr_reg, cur_addr_next;
    logic [hrp_pkg::ID_W-1:0]     cur_id_reg, cur_id_next;
    logic [hrp_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [hrp_pkg::RINDEX_W-1:0] rcount_reg, rcount_next;
    logic                         halted_reg, halted_next;

    // Decode
    logic [7:0]                 nib;
    logic [7:0]                 byte_val;
    logic [4:0]                 k;
    logic [7:0]                 k8;
    logic [hrp_pkg::POS_W:0]    chars;
    logic                       ends;
    logic                       proceed;
    logic                       cnt_ok;
    logic                       rb_we;
    logic [hrp_pkg::RB_IDX_W-1:0] rb_idx;
    logic                       slot_full;
    logic [8:0]                 need_chars;
    logic [hrp_pkg::PLEN_W-1:0] plen;
    logic                       emit;

    assign nib      = (char_reg >= hrp_pkg::CHAR_A) ? char_reg - hrp_pkg::ALPHA_BASE
                                                    : char_reg - hrp_pkg::CHAR_ZERO;
    assign byte_val = {high_reg, 4'b0000} + nib;
    assign k        = pos_reg[hrp_pkg::POS_W-1:1];
    assign k8       = {3'b000, k};
    assign chars    = {1'b0, pos_reg} + 7'd1;
    assign ends     = end_reg || (chars >= 7'(hrp_pkg::LINE_CHARS - 1));
    assign proceed  = in_valid_reg && (halted_reg || !ends || gen_idle);
    assign in_ready = !in_valid_reg || proceed;
    assign cnt_ok   = (count_reg >= 8'(hrp_pkg::COUNT_MIN))
                   && (count_reg <= 8'(hrp_pkg::RECORD_BYTES));
    assign rb_idx   = hrp_pkg::RB_IDX_W'(k - 5'd2);
    assign slot_full = (cur_addr_reg != 8'd0)
                    && (({1'b0, slot_reg} + 3'd1) >= 3'(hrp_pkg::DEVICES));
    assign need_chars = {count_next, 1'b0} + 9'd4;
    assign plen     = hrp_pkg::PLEN_W'(count_next - 8'(hrp_pkg::COUNT_MIN));

    // Absorb one character into the line state
    always_comb begin
        first_next = first_reg;
        kind_next  = kind_reg;
        high_next  = high_reg;
        count_next = count_reg;
        laddr_next = laddr_reg;
        mark_next  = mark_reg;
        pend_next  = pend_reg;
        crc_next   = crc_reg;
        scrc_next  = scrc_reg;
        rb_we      = 1'b0;

        if (pos_reg == '0) begin
            first_next = char_reg;
        end
        if (pos_reg == hrp_pkg::POS_W'(1)) begin
            if (first_reg == hrp_pkg::CHAR_FOUR && char_reg == hrp_pkg::CHAR_NINE) begin
                kind_next = hrp_pkg::LK_DEVICE;
            end else if (first_reg == hrp_pkg::CHAR_ZERO && char_reg == hrp_pkg::CHAR_ZERO) begin
                kind_next = hrp_pkg::LK_RECORD;
            end else begin
                kind_next = hrp_pkg::LK_IGNORE;
            end
        end

        if (!pos_reg[0]) begin
            high_next = nib[3:0];
        end else if (kind_next == hrp_pkg::LK_DEVICE) begin
            if (k == 5'd2) begin
                laddr_next = byte_val;
            end else if (k == 5'd3) begin
                mark_next = byte_val;
            end else if (k >= 5'd4 && k <= 5'd7) begin
                pend_next = {pend_reg[hrp_pkg::ID_W-9:0], byte_val};
            end
        end else if (kind_next == hrp_pkg::LK_RECORD) begin
            if (k == 5'd1) begin
                count_next = byte_val;
            end else if (k >= 5'd2 && cnt_ok) begin
                if (k8 <= count_reg) begin
                    if (k == 5'd2) begin
                        laddr_next = byte_val;
                    end
                    crc_next = hrp_pkg::crc8_step(crc_reg, byte_val);
                    rb_we    = 1'b1;
                end else if (k8 == count_reg + 8'd1) begin
                    scrc_next = byte_val;
                end
            end else if (k == 5'd2) begin
                laddr_next = byte_val;
            end
        end
    end

    // Decide the line-end result and the device state update
    always_comb begin
        cur_addr_next = cur_addr_reg;
        cur_id_next   = cur_id_reg;
        slot_next     = slot_reg;
        rcount_next   = rcount_reg;
        halted_next   = halted_reg;
        emit          = 1'b0;

        load.kind    = hrp_pkg::KIND_ERROR;
        load.err     = hrp_pkg::ERR_NONE;
        load.command = 8'd0;
        load.plen    = '0;
        load.payload = '0;

        if (kind_next == hrp_pkg::LK_DEVICE) begin
            if (chars >= 7'd16 && mark_next == hrp_pkg::DEVICE_MARK) begin
                emit = 1'b1;
                if (slot_full) begin
                    load.err    = hrp_pkg::ERR_DEVICES;
                    halted_next = 1'b1;
                end else begin
                    if (cur_addr_reg != 8'd0) begin
                        slot_next   = slot_reg + hrp_pkg::SLOT_W'(1);
                        rcount_next = '0;
                    end
                    cur_addr_next = laddr_next;
                    cur_id_next   = pend_next;
                    load.kind     = hrp_pkg::KIND_DEVICE;
                end
            end
        end else if (kind_next == hrp_pkg::LK_RECORD) begin
            emit = 1'b1;
            if (count_next < 8'(hrp_pkg::COUNT_MIN)
                    || count_next > 8'(hrp_pkg::RECORD_BYTES)) begin
                load.err    = hrp_pkg::ERR_COUNT;
                halted_next = 1'b1;
            end else if (laddr_next != cur_addr_reg) begin
                load.err    = hrp_pkg::ERR_ADDRESS;
                halted_next = 1'b1;
            end else if ({2'b00, chars} < need_chars || crc_next != scrc_next) begin
                load.err    = hrp_pkg::ERR_CRC;
                halted_next = 1'b1;
            end else begin
                load.kind    = hrp_pkg::KIND_RECORD;
                load.command = rb_reg[1];
                load.plen    = plen;
                for (int i = 0; i < hrp_pkg::PAYLOAD_MAX; i++) begin
                    load.payload[i] = (i < int'(plen)) ? rb_reg[i + 2] : 8'd0;
                end
                rcount_next = rcount_reg + hrp_pkg::RINDEX_W'(1);
            end
        end

        // Device results show the updated device, others the current one
        load.slot    = slot_next;
        load.address = cur_addr_next;
        load.id      = cur_id_next;
        load.rindex  = (load.kind == hrp_pkg::KIND_DEVICE) ? rcount_next : rcount_reg;
    end

    assign pos_next   = pos_reg + hrp_pkg::POS_W'(1);
    assign load_valid = proceed && !halted_reg && ends && emit;

    // Hold the input beat until it is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proceed) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            char_reg <= in_char;
            end_reg  <= in_end;
        end
    end

    // Advance line and device state; clear line state at line end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            kind_reg     <= hrp_pkg::LK_NONE;
            first_reg    <= 8'd0;
            high_reg     <= 4'd0;
            count_reg    <= 8'd0;
            laddr_reg    <= 8'd0;
            mark_reg     <= 8'd0;
            pend_reg     <= '0;
            crc_reg      <= 8'd0;
            scrc_reg     <= 8'd0;
            cur_addr_reg <= 8'd0;
            cur_id_reg   <= '0;
            slot_reg     <= '0;
            rcount_reg   <= '0;
            halted_reg   <= 1'b0;
        end else if (proceed && !halted_reg) begin
            if (ends) begin
                pos_reg      <= '0;
                kind_reg     <= hrp_pkg::LK_NONE;
                first_reg    <= 8'd0;
                high_reg     <= 4'd0;
                count_reg    <= 8'd0;
                laddr_reg    <= 8'd0;
                mark_reg     <= 8'd0;
                pend_reg     <= '0;
                crc_reg      <= 8'd0;
                scrc_reg     <= 8'd0;
                cur_addr_reg <= cur_addr_next;
                cur_id_reg   <= cur_id_next;
                slot_reg     <= slot_next;
                rcount_reg   <= rcount_next;
                halted_reg   <= halted_next;
            end else begin
                pos_reg   <= pos_next;
                kind_reg  <= kind_next;
                first_reg <= first_next;
                high_reg  <= high_next;
                count_reg <= count_next;
                laddr_reg <= laddr_next;
                mark_reg  <= mark_next;
                pend_reg  <= pend_next;
                crc_reg   <= crc_next;
                scrc_reg  <= scrc_next;
            end
        end
    end

    // Record byte store: one write port, read at fixed places
    always_ff @(posedge aclk) begin
        if (proceed && !halted_reg && rb_we) begin
            rb_reg[rb_idx] <= byte_val;
        end
    end

endmodule

FILE: src/hrp_result_gen.sv
// ----------------------------------------------------------------------------
// hrp_result_gen
// Result register: holds a run, one beat per payload byte or one if none.
// ----------------------------------------------------------------------------
module hrp_result_gen (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load_valid,
    input  hrp_pkg::run_load_t            load,
    output logic                          idle,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hrp_pkg::rec_kind_t            out_kind,
    output hrp_pkg::err_code_t            out_err,
    output logic [hrp_pkg::SLOT_W-1:0]    out_slot,
    output logic [7:0]                    out_address,
    output logic [hrp_pkg::ID_W-1:0]      out_id,
    output logic [hrp_pkg::RINDEX_W-1:0]  out_rindex,
    output logic [7:0]                    out_command,
    output logic [hrp_pkg::PLEN_W-1:0]    out_plen,
    output logic [hrp_pkg::PLEN_W-1:0]    out_bidx,
    output logic [7:0]                    out_pbyte,
    output logic                          out_last
);

    logic                              valid_reg;
    hrp_pkg::rec_kind_t                kind_reg;
    hrp_pkg::err_code_t                err_reg;
    logic [hrp_pkg::SLOT_W-1:0]        slot_reg;
    logic [7:0]                        addr_reg;
    logic [hrp_pkg::ID_W-1:0]          id_reg;
    logic [hrp_pkg::RINDEX_W-1:0]      rindex_reg;
    logic [7:0]                        cmd_reg;
    logic [hrp_pkg::PLEN_W-1:0]        plen_reg;
    logic [hrp_pkg::PLEN_W-1:0]        bidx_reg;
    logic [hrp_pkg::PAYLOAD_MAX-1:0][7:0] pbuf_reg;
    logic                              beat;

    assign out_last = (kind_reg != hrp_pkg::KIND_RECORD) || (plen_reg == '0)
                   || (bidx_reg + hrp_pkg::PLEN_W'(1) == plen_reg);
    assign beat     = valid_reg && out_ready;
    assign idle     = !valid_reg;

    // Load a run, drop it after its last beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_valid) begin
            valid_reg <= 1'b1;
        end else if (beat && out_last) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload registers: load, then shift one byte per beat until the last
    always_ff @(posedge aclk) begin
        if (load_valid) begin
            kind_reg   <= load.kind;
            err_reg    <= load.err;
            slot_reg   <= load.slot;
            addr_reg   <= load.address;
            id_reg     <= load.id;
            rindex_reg <= load.rindex;
            cmd_reg    <= load.command;
            plen_reg   <= load.plen;
            bidx_reg   <= '0;
            pbuf_reg   <= load.payload;
        end else if (beat && !out_last) begin
            bidx_reg <= bidx_reg + hrp_pkg::PLEN_W'(1);
            pbuf_reg <= {8'd0, pbuf_reg[hrp_pkg::PAYLOAD_MAX-1:1]};
        end
    end

    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_err     = err_reg;
    assign out_slot    = slot_reg;
    assign out_address = addr_reg;
    assign out_id      = id_reg;
    assign out_rindex  = rindex_reg;
    assign out_command = cmd_reg;
    assign out_plen    = plen_reg;
    assign out_bidx    = bidx_reg;
    assign out_pbyte   = pbuf_reg[0];

endmodule

FILE: src/hex_record_parser_crc8.sv
// ----------------------------------------------------------------------------
// hex_record_parser_crc8
// Parses an ASCII hex image stream into device and command record results.
// ----------------------------------------------------------------------------
// Path: a line-ending character reaches its first result through the input
//   register, then the result register.
// Throughput: one character per cycle; a record run of n payload bytes takes
//   n output beats (one when n is zero), and a line end (unless halted) waits in
//   the input register until the previous run has fully left the result register.
// Reset: synchronous, active low; clears line, device and halt state. The
//   record byte store is not cleared.
module hex_record_parser_crc8 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,   // line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] error_code, [4:3] device_slot, [12:5] device_address,
    // [44:13] device_id, [55:45] record_index, [63:56] command,
    // [67:64] payload_length, [71:68] byte_index, [79:72] payload_byte
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] record_kind
    output logic        m_tlast    // last
);

    logic                          gen_idle;
    logic                          load_valid;
    hrp_pkg::run_load_t            load;
    hrp_pkg::rec_kind_t            out_kind;
    hrp_pkg::err_code_t            out_err;
    logic [hrp_pkg::SLOT_W-1:0]    out_slot;
    logic [7:0]                    out_address;
    logic [hrp_pkg::ID_W-1:0]      out_id;
    logic [hrp_pkg::RINDEX_W-1:0]  out_rindex;
    logic [7:0]                    out_command;
    logic [hrp_pkg::PLEN_W-1:0]    out_plen;
    logic [hrp_pkg::PLEN_W-1:0]    out_bidx;
    logic [7:0]                    out_pbyte;

    hrp_line_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_char    (s_tdata),
        .in_end     (s_tlast),
        .gen_idle   (gen_idle),
        .load_valid (load_valid),
        .load       (load)
    );

    hrp_result_gen u_gen (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_valid  (load_valid),
        .load        (load),
        .idle        (gen_idle),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (out_kind),
        .out_err     (out_err),
        .out_slot    (out_slot),
        .out_address (out_address),
        .out_id      (out_id),
        .out_rindex  (out_rindex),
        .out_command (out_command),
        .out_plen    (out_plen),
        .out_bidx    (out_bidx),
        .out_pbyte   (out_pbyte),
        .out_last    (m_tlast)
    );

    // Pack the result beat
    assign m_tdata = {out_pbyte, out_bidx, out_plen, out_command, out_rindex,
                      out_id, out_address, out_slot, out_err};
    assign m_tuser = out_kind;

endmodule

FILE: src/hrp_checker.sv
// ----------------------------------------------------------------------------
// hrp_checker
// Port-level checks of the hex record parser, bound to the top level.
// ----------------------------------------------------------------------------
module hrp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // No result beat right after reset
    assert property (@(posedge aclk) $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

    // Stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // Error code set exactly on error results
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == hrp_pkg::KIND_ERROR) == (m_tdata[2:0] != 3'd0)))
        else $error("error code and kind disagree");

    // Device and error results stand alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != hrp_pkg::KIND_RECORD |-> m_tlast)
        else $error("single result without last");

    // A run ends on its final payload byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == hrp_pkg::KIND_RECORD && m_tlast && m_tdata[67:64] != 4'd0
            |-> m_tdata[71:68] + 4'd1 == m_tdata[67:64])
        else $error("run ends early or late");

endmodule

bind hex_record_parser_crc8 hrp_checker u_hrp_checker (.*);

FILE: bench/tb_hex_record_parser_crc8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_record_parser_crc8
// Streams hex image lines (device lines, command records, noise) into the
// parser, predicts every device, record-byte and error beat in a behavioral
// parser kept in step with the accepted characters, and checks each output
// beat field by field under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_hex_record_parser_crc8;
    import hrp_pkg::*;

    localparam int CYCLE_LIMIT        = 500_000;
    localparam int RECORDS_PER_DEVICE = 1 << RINDEX_W;
    localparam int HOLD_CYCLES        = 300;
    localparam int DRAIN_CYCLES       = 16;

    // One expected output beat
    typedef struct {
        rec_kind_t             kind;
        err_code_t             err;
        logic [SLOT_W-1:0]     slot;
        logic [7:0]            addr;
        logic [ID_W-1:0]       id;
        logic [RINDEX_W-1:0]   rindex;
        logic [7:0]            command;
        logic [PLEN_W-1:0]     plen;
        logic [3:0]            bidx;
        logic [7:0]            pbyte;
        logic                  last;
    } parse_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    hex_record_parser_crc8 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Parser model state: current line
    logic [POS_W-1:0]    ln_pos;
    line_kind_t          ln_kind;
    logic [3:0]          ln_high;
    logic [7:0]          ln_first;
    logic [7:0]          ln_count;
    logic [7:0]          ln_addr;
    logic [7:0]          ln_mark;
    logic [ID_W-1:0]     ln_id;
    logic [7:0]          ln_crc;
    logic [7:0]          ln_crc_rx;
    logic [7:0]          rec_store [RECORD_BYTES];

    // Parser model state: device tracking
    logic [7:0]          dev_addr;
    logic [ID_W-1:0]     dev_id;
    logic [SLOT_W-1:0]   dev_slot;
    logic [RINDEX_W-1:0] dev_records;
    bit                  parse_halted;

    parse_result_t       pending_results[$];
    parse_result_t       want_result;
    int                  results_expected = 0;
    int                  parsed_chars     = 0;
    int                  mismatches       = 0;
    int                  cycle_count      = 0;

    // Stimulus controls
    int                  send_idle_pct = 0;
    int                  rx_stall_pct  = 0;
    int                  hold_requests = 0;
    int                  hold_seen     = 0;
    int                  hold_left     = 0;
    logic [7:0]          line_buf[$];
    logic [7:0]          record_data[$];

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        return (c >= CHAR_A) ? c - ALPHA_BASE : c - CHAR_ZERO;
    endfunction

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        return r;
    endfunction

    function automatic void clear_line_state();
        ln_pos    = '0;
        ln_kind   = LK_NONE;
        ln_high   = '0;
        ln_first  = '0;
        ln_count  = '0;
        ln_addr   = '0;
        ln_mark   = '0;
        ln_id     = '0;
        ln_crc    = '0;
        ln_crc_rx = '0;
    endfunction

    function automatic void push_result(input rec_kind_t kind, input err_code_t err,
                                        input logic [7:0] cmd, input logic [3:0] plen,
                                        input logic [3:0] bidx, input logic [7:0] pbyte,
                                        input logic last);
        parse_result_t r;
        r.kind    = kind;
        r.err     = err;
        r.slot    = dev_slot;
        r.addr    = dev_addr;
        r.id      = dev_id;
        r.rindex  = dev_records;
        r.command = cmd;
        r.plen    = plen;
        r.bidx    = bidx;
        r.pbyte   = pbyte;
        r.last    = last;
        pending_results.push_back(r);
        results_expected++;
    endfunction

    function automatic void halt_with(input err_code_t code);
        parse_halted = 1'b1;
        push_result(KIND_ERROR, code, 8'h00, 4'h0, 4'h0, 8'h00, 1'b1);
    endfunction

    // Advance the model by one accepted character
    function automatic void parse_char(input logic [7:0] c, input logic eol);
        logic [7:0]      n, b, cnt, addr, mark;
        logic [ID_W-1:0] id;
        int              k, chars, plen;
        line_kind_t      kind;
        bit              crc_ok;
        if (parse_halted) return;
        if (ln_pos == 0) ln_first = c;
        if (ln_pos == 1) begin
            if (ln_first == CHAR_FOUR && c == CHAR_NINE) ln_kind = LK_DEVICE;
            else if (ln_first == CHAR_ZERO && c == CHAR_ZERO) ln_kind = LK_RECORD;
            else ln_kind = LK_IGNORE;
        end
        n = digit_value(c);
        k = int'(ln_pos) >> 1;
        if (!ln_pos[0]) begin
            ln_high = n[3:0];
        end else begin
            b = {ln_high, 4'h0} + n;
            if (ln_kind == LK_DEVICE) begin
                if (k == 2) ln_addr = b;
                else if (k == 3) ln_mark = b;
                else if (k >= 4 && k <= 7) ln_id = {ln_id[23:0], b};
            end else if (ln_kind == LK_RECORD) begin
                if (k == 1) begin
                    ln_count = b;
                end else if (k >= 2 && ln_count >= COUNT_MIN && ln_count <= RECORD_BYTES) begin
                    if (k <= int'(ln_count)) begin
                        if (k == 2) ln_addr = b;
                        ln_crc = crc8_update(ln_crc, b);
                        rec_store[k - 2] = b;
                    end else if (k == int'(ln_count) + 1) begin
                        ln_crc_rx = b;
                    end
                end else if (k == 2) begin
                    ln_addr = b;
                end
            end
        end
        chars  = int'(ln_pos) + 1;
        ln_pos = ln_pos + 1'b1;
        if (!eol && chars < LINE_CHARS - 1) return;

        // Line complete: latch what it carried and start over
        kind   = ln_kind;
        addr   = ln_addr;
        cnt    = ln_count;
        mark   = ln_mark;
        id     = ln_id;
        crc_ok = (ln_crc == ln_crc_rx);
        clear_line_state();

        if (kind == LK_DEVICE) begin
            if (chars < 16 || mark != DEVICE_MARK) return;
            if (dev_addr != 8'h00) begin
                if (int'(dev_slot) + 1 >= DEVICES) begin
                    halt_with(ERR_DEVICES);
                    return;
                end
                dev_slot    = dev_slot + 1'b1;
                dev_records = '0;
            end
            dev_addr = addr;
            dev_id   = id;
            push_result(KIND_DEVICE, ERR_NONE, 8'h00, 4'h0, 4'h0, 8'h00, 1'b1);
        end else if (kind == LK_RECORD) begin
            if (cnt < COUNT_MIN || cnt > RECORD_BYTES) begin
                halt_with(ERR_COUNT);
            end else if (addr != dev_addr) begin
                halt_with(ERR_ADDRESS);
            end else if (chars < 2 * int'(cnt) + 4 || !crc_ok) begin
                halt_with(ERR_CRC);
            end else begin
                plen = int'(cnt) - 3;
                if (plen == 0) begin
                    push_result(KIND_RECORD, ERR_NONE, rec_store[1], 4'h0, 4'h0, 8'h00, 1'b1);
                end else begin
                    for (int i = 0; i < plen; i++) begin
                        push_result(KIND_RECORD, ERR_NONE, rec_store[1], 4'(plen), 4'(i),
                                    rec_store[2 + i], i == plen - 1);
                    end
                end
                dev_records = dev_records + 1'b1;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Line builders
    // ------------------------------------------------------------------

    // Append one byte as two uppercase hex characters
    function automatic void put_byte(input logic [7:0] b);
        for (int i = 1; i >= 0; i--) begin
            line_buf.push_back(b[4*i +: 4] < 10 ? CHAR_ZERO + b[4*i +: 4]
                                                 : ALPHA_BASE + b[4*i +: 4]);
        end
    endfunction

    // Append two arbitrary characters and return the byte they decode to
    function automatic logic [7:0] put_scrambled();
        logic [7:0] hi, lo;
        hi = 8'($urandom_range(255));
        lo = 8'($urandom_range(255));
        line_buf.push_back(hi);
        line_buf.push_back(lo);
        return {digit_value(hi)[3:0], 4'h0} + digit_value(lo);
    endfunction

    // Command record from record_data; scrambled bytes still carry a valid CRC
    function automatic void build_record(input logic [7:0] count_byte, input logic [7:0] addr,
                                         input int scramble_pct, input logic [7:0] crc_flip);
        logic [7:0] crc, b;
        line_buf.delete();
        line_buf.push_back(CHAR_ZERO);
        line_buf.push_back(CHAR_ZERO);
        put_byte(count_byte);
        put_byte(addr);
        crc = crc8_update(8'h00, addr);
        foreach (record_data[i]) begin
            if ($urandom_range(99) < scramble_pct) begin
                b = put_scrambled();
            end else begin
                b = record_data[i];
                put_byte(b);
            end
            crc = crc8_update(crc, b);
        end
        put_byte(crc ^ crc_flip);
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    task automatic send_char(input logic [7:0] c, input logic eol);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        parse_char(c, eol);
    endtask

    task automatic send_line(input logic with_end, input bit counted);
        int n;
        n = line_buf.size();
        for (int i = 0; i < n; i++) send_char(line_buf[i], with_end && (i == n - 1));
        if (counted) parsed_chars += n;
    endtask

    task automatic send_random_record(input int n_data, input int scramble_pct);
        record_data.delete();
        repeat (n_data) record_data.push_back(8'($urandom_range(255)));
        build_record(8'(n_data + 2), dev_addr, scramble_pct, 8'h00);
        send_line(1'b1, 1'b1);
    endtask

    // flaw: 0 well formed, 1 wrong mark byte, 2 cut short
    task automatic send_device_line(input logic [7:0] addr, input logic [ID_W-1:0] id,
                                    input int flaw);
        logic [7:0] mark;
        int         trim;
        mark = (flaw == 1) ? (DEVICE_MARK ^ 8'($urandom_range(1, 255))) : DEVICE_MARK;
        line_buf.delete();
        line_buf.push_back(CHAR_FOUR);
        line_buf.push_back(CHAR_NINE);
        put_byte(8'($urandom_range(255)));
        put_byte(addr);
        put_byte(mark);
        put_byte(id[31:24]);
        put_byte(id[23:16]);
        put_byte(id[15:8]);
        put_byte(id[7:0]);
        if (flaw == 2) begin
            trim = $urandom_range(2, 15);
            while (line_buf.size() > trim) void'(line_buf.pop_back());
        end
        send_line(1'b1, 1'b1);
    endtask

    // Random characters that never open a device or record line
    task automatic send_noise_line(input int len);
        line_buf.delete();
        repeat (len) line_buf.push_back(8'($urandom_range(255)));
        if (len >= 2 && ((line_buf[0] == CHAR_FOUR && line_buf[1] == CHAR_NINE) ||
                         (line_buf[0] == CHAR_ZERO && line_buf[1] == CHAR_ZERO)))
            line_buf[1] = "Z";
        send_line(1'b1, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    // Random stalls, plus a long hold-off whenever a test asks for one
    always @(posedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches < 50)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name,
                         want, got);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches < 50)
                    $display("%0t ns: unexpected beat, expected none, actual %h/%h/%b",
                             $time, m_tuser, m_tdata, m_tlast);
            end else begin
                want_result = pending_results.pop_front();
                check_field("record_kind",    want_result.kind,    m_tuser);
                check_field("error_code",     want_result.err,     m_tdata[2:0]);
                check_field("device_slot",    want_result.slot,    m_tdata[4:3]);
                check_field("device_address", want_result.addr,    m_tdata[12:5]);
                check_field("device_id",      want_result.id,      m_tdata[44:13]);
                check_field("record_index",   want_result.rindex,  m_tdata[55:45]);
                check_field("command",        want_result.command, m_tdata[63:56]);
                check_field("payload_length", want_result.plen,    m_tdata[67:64]);
                check_field("byte_index",     want_result.bidx,    m_tdata[71:68]);
                check_field("payload_byte",   want_result.pbyte,   m_tdata[79:72]);
                check_field("last",           want_result.last,    m_tlast);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Records before any device, empty and full payloads, trailing and long lines
    task automatic test_directed_records();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        record_data = '{8'h5c};
        build_record(8'd3, dev_addr, 0, 8'h00);
        send_line(1'b1, 1'b1);
        record_data.delete();
        record_data.push_back(8'h00);
        repeat (PAYLOAD_MAX) record_data.push_back(8'hff);
        build_record(8'(RECORD_BYTES), dev_addr, 0, 8'h00);
        send_line(1'b1, 1'b1);
        record_data.delete();
        record_data.push_back(8'hff);
        repeat (PAYLOAD_MAX) record_data.push_back(8'h00);
        build_record(8'(RECORD_BYTES), dev_addr, 0, 8'h00);
        send_line(1'b1, 1'b1);
        // junk after the CRC byte is ignored
        record_data.delete();
        repeat (5) record_data.push_back(8'($urandom_range(255)));
        build_record(8'd7, dev_addr, 0, 8'h00);
        repeat (6) line_buf.push_back(8'($urandom_range(255)));
        send_line(1'b1, 1'b1);
        // no line end: the line closes on its own at the length limit
        record_data.delete();
        repeat (RECORD_BYTES - 2) record_data.push_back(8'($urandom_range(255)));
        build_record(8'(RECORD_BYTES), dev_addr, 0, 8'h00);
        while (line_buf.size() < LINE_CHARS - 1) line_buf.push_back(CHAR_ZERO);
        send_line(1'b0, 1'b1);
    endtask

    // Ignored device lines, slot reuse while no address is set, slot advance
    task automatic test_directed_devices();
        send_device_line(8'h33, $urandom, 2);
        send_device_line(8'h33, $urandom, 1);
        send_device_line(8'h00, 32'hffff_ffff, 0);
        send_random_record(4, 0);
        send_device_line(8'hff, 32'h0000_0000, 0);
        send_random_record(1, 0);
        send_device_line(8'h01, $urandom, 0);
        send_random_record(RECORD_BYTES - 2, 0);
    endtask

    // Lines of no interest, long lines and high characters inside records
    task automatic test_directed_lines();
        send_noise_line(1);
        send_noise_line(40);
        line_buf.delete();
        repeat (70) line_buf.push_back("Z");
        send_line(1'b1, 1'b0);
        line_buf = '{CHAR_ZERO, "1"};
        repeat (10) put_byte(8'($urandom_range(255)));
        send_line(1'b1, 1'b0);
        line_buf = '{CHAR_FOUR, "8"};
        repeat (10) put_byte(8'($urandom_range(255)));
        send_line(1'b1, 1'b0);
        send_random_record(12, 100);
    endtask

    // Run the per-device record index through its wrap
    task automatic test_record_index_wrap();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        repeat (RECORDS_PER_DEVICE + 4) send_random_record(1, 0);
    endtask

    // Hold the output off long enough that the parser stalls its input
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        hold_requests++;
        repeat (8) send_random_record($urandom_range(6, 14), 10);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int chars_start, results_start, pick;
        send_idle_pct = idle_pct;
        rx_stall_pct  = stall_pct;
        chars_start   = parsed_chars;
        results_start = results_expected;
        while (parsed_chars - chars_start < 60 || results_expected - results_start < 20) begin
            pick = $urandom_range(99);
            if (pick < 10 && (dev_addr == 8'h00 || int'(dev_slot) + 1 < DEVICES))
                send_device_line(8'($urandom_range(255)), $urandom, 0);
            else if (pick < 18)
                send_noise_line($urandom_range(1, 50));
            else if (pick < 25)
                send_device_line(8'($urandom_range(255)), $urandom, $urandom_range(1, 2));
            else
                send_random_record($urandom_range(1, RECORD_BYTES - 2), 20);
        end
    endtask

    // One fault per run, since only reset clears the halt; then confirm silence
    task automatic test_halt_on_error();
        int         mode;
        logic [7:0] count_byte, addr, crc_flip;
        send_idle_pct = 10;
        rx_stall_pct  = 10;
        mode = $urandom_range(3);
        if (mode == 0) begin
            while (!parse_halted) send_device_line(8'($urandom_range(1, 255)), $urandom, 0);
        end else begin
            record_data.delete();
            repeat ($urandom_range(1, RECORD_BYTES - 2))
                record_data.push_back(8'($urandom_range(255)));
            count_byte = 8'(record_data.size() + 2);
            addr       = dev_addr;
            crc_flip   = 8'h00;
            if (mode == 1)
                count_byte = $urandom_range(1) ? 8'($urandom_range(2))
                                               : 8'($urandom_range(RECORD_BYTES + 1, 255));
            if (mode == 2 || (mode == 1 && $urandom_range(1)))
                addr = dev_addr ^ 8'($urandom_range(1, 255));
            if (mode == 3 || $urandom_range(1))
                crc_flip = 8'($urandom_range(1, 255));
            build_record(count_byte, addr, 0, crc_flip);
            if (mode == 3 && $urandom_range(1)) begin
                crc_flip = 8'h00;
                build_record(count_byte, addr, 0, crc_flip);
                repeat ($urandom_range(1, 2)) void'(line_buf.pop_back());
            end
            send_line(1'b1, 1'b1);
        end
        repeat (2) send_random_record($urandom_range(1, RECORD_BYTES - 2), 0);
        send_device_line(8'($urandom_range(1, 255)), $urandom, 0);
    endtask

    initial begin
        clear_line_state();
        dev_addr     = '0;
        dev_id       = '0;
        dev_slot     = '0;
        dev_records  = '0;
        parse_halted = 1'b0;
        foreach (rec_store[i]) rec_store[i] = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_records();
        test_directed_devices();
        test_directed_lines();
        test_record_index_wrap();
        test_output_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(50, 0);
        test_random_traffic(0, 50);
        test_random_traffic(10, 10);
        test_halt_on_error();
        s_tvalid <= 1'b0;

        // Drain outstanding beats, then allow for anything spurious
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/hrp_pkg.sv
src/hrp_line_parser.sv
src/hrp_result_gen.sv
src/hex_record_parser_crc8.sv
src/hrp_checker.sv
bench/tb_hex_record_parser_crc8.sv
